// ===== hw/rtl/sfr_pkg.sv =====
package sfr_pkg;

  localparam int unsigned CHAR_W      = 16;
  localparam int unsigned MAX_CHARS   = 8;
  localparam int unsigned LEN_W       = 4;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned IDX_W       = 3;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef logic [CHAR_W-1:0] char_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LEN = 3'd0,
    REG_PAT_LO  = 3'd1,
    REG_PAT_HI  = 3'd2,
    REG_REP_LEN = 3'd3,
    REG_REP_LO  = 3'd4,
    REG_REP_HI  = 3'd5
  } cfg_reg_e;

  // one burst of results caused by one input item
  typedef struct packed {
    char_t [MAX_CHARS-1:0] chars;
    logic [CNT_W-1:0]      count;
    logic                  last;
  } cmd_t;

endpackage

// ===== hw/rtl/sfr_front.sv =====
module sfr_front #(
  parameter int unsigned MAX_PATTERN = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  sfr_pkg::char_t                   in_char_i,
  input  logic                             in_last_i,
  input  logic                             q_full_i,
  output logic                             push_o,
  output sfr_pkg::cmd_t                    cmd_o
);
  import sfr_pkg::*;

  localparam int unsigned FILL_W = $clog2(MAX_PATTERN + 1);

  logic [LEN_W-1:0]        pat_len_q;
  logic [CFG_DATA_W-1:0]   pat_lo_q, pat_hi_q;
  logic [CNT_W-1:0]        rep_len_q;
  logic [CFG_DATA_W-1:0]   rep_lo_q, rep_hi_q;
  char_t                   win_q [MAX_PATTERN];
  char_t                   win_d [MAX_PATTERN];
  char_t                   win_new [MAX_PATTERN];
  logic [FILL_W-1:0]       fill_q, fill_d, fill_eff;
  logic [LEN_W-1:0]        plen, fill_inc;
  logic [CNT_W-1:0]        rlen;
  logic [2*CFG_DATA_W-1:0] pat_all, rep_all;
  logic [MAX_PATTERN-1:0]  hit_ok;
  logic                    full_hit, match, accept;
  cmd_t                    cmd;

  assign accept     = in_valid_i && !q_full_i;
  assign in_ready_o = !q_full_i;
  assign pat_all    = {pat_hi_q, pat_lo_q};
  assign rep_all    = {rep_hi_q, rep_lo_q};

  assign plen = (pat_len_q > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : pat_len_q;
  assign rlen = (rep_len_q > CNT_W'(MAX_CHARS)) ? CNT_W'(MAX_CHARS) : rep_len_q;
  assign fill_eff = (LEN_W'(fill_q) >= plen) ? '0 : fill_q;
  assign fill_inc = LEN_W'(fill_eff) + LEN_W'(1);
  assign full_hit = (plen != '0) && (fill_inc == plen);

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      win_new[i] = (FILL_W'(i) == fill_eff) ? in_char_i : win_q[i];
      hit_ok[i]  = (LEN_W'(i) >= plen) || (win_new[i] == pat_all[CHAR_W*i +: CHAR_W]);
    end
  end

  assign match = full_hit && (&hit_ok);

  // classify the item into one result burst and the next window
  always_comb begin
    cmd.chars = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      cmd.chars[i] = win_new[i];
    end
    cmd.count = '0;
    cmd.last  = in_last_i;
    win_d     = win_new;
    fill_d    = '0;
    if (plen == '0) begin
      cmd.chars[0] = in_char_i;
      cmd.count    = CNT_W'(1);
    end else if (match) begin
      for (int i = 0; i < MAX_CHARS; i++) begin
        cmd.chars[i] = rep_all[CHAR_W*i +: CHAR_W];
      end
      cmd.count = rlen;
    end else if (full_hit) begin
      cmd.count = in_last_i ? CNT_W'(plen) : CNT_W'(1);
      fill_d    = in_last_i ? '0 : FILL_W'(plen - LEN_W'(1));
      for (int i = 0; i < MAX_PATTERN - 1; i++) begin
        win_d[i] = win_new[i+1];
      end
    end else begin
      cmd.count = in_last_i ? CNT_W'(fill_inc) : '0;
      fill_d    = in_last_i ? '0 : FILL_W'(fill_inc);
    end
  end

  assign cmd_o  = cmd;
  assign push_o = accept && ((cmd.count != '0) || in_last_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q <= '0;
      pat_lo_q  <= '0;
      pat_hi_q  <= '0;
      rep_len_q <= '0;
      rep_lo_q  <= '0;
      rep_hi_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_PAT_LEN: pat_len_q <= cfg_wdata_i[LEN_W-1:0];
        REG_PAT_LO:  pat_lo_q  <= cfg_wdata_i;
        REG_PAT_HI:  pat_hi_q  <= cfg_wdata_i;
        REG_REP_LEN: rep_len_q <= cfg_wdata_i[CNT_W-1:0];
        REG_REP_LO:  rep_lo_q  <= cfg_wdata_i;
        REG_REP_HI:  rep_hi_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (cfg_we_i && (cfg_index_i == REG_PAT_LEN)) begin
      fill_q <= '0;
    end else if (accept) begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      win_q <= win_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    LEN_W'(fill_q) < LEN_W'(MAX_PATTERN))
    else $error("window fill out of range");

endmodule

// ===== hw/rtl/sfr_queue.sv =====
module sfr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sfr_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output sfr_pkg::cmd_t head_o
);
  import sfr_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_QW = $clog2(QUEUE_DEPTH + 1);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_QW-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_QW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_QW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_QW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== hw/rtl/sfr_back.sv =====
module sfr_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  sfr_pkg::cmd_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output sfr_pkg::char_t out_char_o,
  output logic          out_last_o,
  output logic          out_empty_o
);
  import sfr_pkg::*;

  logic [IDX_W-1:0] idx_q;
  logic             out_valid_q, out_last_q, out_empty_q;
  char_t            out_char_q;
  logic             ld, final_item, no_chars;

  assign no_chars   = (head_i.count == '0);
  assign final_item = no_chars || ((CNT_W'(idx_q) + CNT_W'(1)) == head_i.count);
  assign ld         = !q_empty_i && (!out_valid_q || out_ready_i);
  assign pop_o      = ld && final_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (ld) begin
        out_valid_q <= 1'b1;
        idx_q       <= final_item ? '0 : idx_q + IDX_W'(1);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      out_char_q  <= no_chars ? '0 : head_i.chars[idx_q];
      out_last_q  <= final_item && head_i.last;
      out_empty_q <= no_chars;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;
  assign out_empty_o = out_empty_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_empty_q |-> out_last_q)
    else $error("empty item without last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_empty_q |-> out_char_q == '0)
    else $error("empty item carries a character");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld && !no_chars |-> CNT_W'(idx_q) < head_i.count)
    else $error("burst index past count");

endmodule

// ===== hw/rtl/stream_find_replace_top.sv =====
// streaming find and replace on 16-bit characters
// input stream: s_axis_tdata carries one character, s_axis_tlast marks the
// final character of a string. output stream: m_axis_tdata carries one
// result character, m_axis_tlast ends the result string, m_axis_tuser high
// marks an item with no character that only ends an empty result.
// configuration: cfg_we_i writes cfg_wdata_i into register cfg_index_i
// (0 pattern length, 1/2 pattern chars 0-3/4-7, 3 replacement length,
// 4/5 replacement chars 0-3/4-7); write only while the block is idle.
// writing the pattern length discards the held window.
// flow: the results of an accepted item are written into the queue and then
// loaded into the output register, one at a time, once that register is
// free. an item yields 0 to 8 results; while m_axis_tready is high the
// output stage sends one result per cycle, so the rate is one item per
// cycle while items yield at most one result each, and an item with
// several results holds the output until all of them are sent.
// a two-entry queue between classifier and output stage absorbs bursts;
// s_axis_tready drops only when that queue is full.
// reset empties the window and the queue, clears m_axis_tvalid and sets all
// configuration registers to zero (pass through). when m_axis_tready is low
// the output item holds and the queue fills, then input stalls.
module stream_find_replace_top #(
  parameter int unsigned MAX_PATTERN = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [15:0]                    s_axis_tdata,  // in_char
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [15:0]                    m_axis_tdata,  // out_char
  output logic                           m_axis_tlast,
  output logic                           m_axis_tuser   // out_empty
);
  import sfr_pkg::*;

  logic push, pop, q_full, q_empty;
  cmd_t cmd, head;

  sfr_front #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_char_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .q_full_i    (q_full),
    .push_o      (push),
    .cmd_o       (cmd)
  );

  sfr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .head_o  (head)
  );

  sfr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_empty_o (m_axis_tuser)
  );

endmodule
